// File: rtl/ggx_nde_pkg.sv
// Package for the GGX normal density evaluation unit.
// Request/response payload types, register indexes and fixed constants.
// No dependencies.
`default_nettype none
package ggx_nde_pkg;

   localparam int DIR_FRAC_BITS = 14;

   localparam logic [16:0] ROUGH_ONE  = 17'd65536;
   localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

   localparam logic REG_ROUGH_X = 1'b0;
   localparam logic REG_ROUGH_Y = 1'b1;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [31:0] density;
      logic        saturated;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/ggx_normal_density_eval_unit.sv
// GGX normal density evaluation unit, top level.
// Pipelined datapath with bit-per-stage dividers; uses ggx_nde_pkg.
//
// Usage:
//   req_valid/req_stall/req_data carry one unit direction per request.
//   rsp_valid/rsp_stall/rsp_data return density (Q16.16) and a saturated flag,
//   one response per request, in request order.
//   Two roughness registers sit on the APB-style port at byte addresses 0 and 4.
// Throughput: one request per cycle while the receiver does not stall.
// Depth: set by two restoring dividers (63 stages, one quotient bit each)
//   and the reciprocal divider (32 stages), plus squaring, sum, normalize
//   and shift stages.
// Stall: when a response waits with rsp_stall high, the whole pipeline holds
//   and req_stall rises; nothing is dropped or repeated.
// Reset: synchronous, clears all valid bits, sets roughness registers to 1.0.
//   Users must write registers while no request is in flight; not enforced.
`default_nettype none
module ggx_normal_density_eval_unit
   import ggx_nde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int DIV_STEPS = 63;
   localparam int RD_STEPS  = 32;
   localparam logic signed [9:0] SH_BIAS = 10'(4 * DIR_FRAC_BITS - 144);

   typedef struct packed {
      logic        vld;
      logic [15:0] ux;
      logic [15:0] uy;
      logic [15:0] uz;
      logic [16:0] ax;
      logic [16:0] ay;
   } s1_type;

   typedef struct packed {
      logic        vld;
      logic [32:0] rem_x;
      logic [62:0] num_x;
      logic [62:0] quo_x;
      logic [32:0] den_x;
      logic [32:0] rem_z;
      logic [62:0] num_z;
      logic [62:0] quo_z;
      logic [32:0] den_z;
      logic [30:0] sqy;
      logic [32:0] axy;
      logic        zy;
      logic        za;
   } dv_type;

   typedef struct packed {
      logic        vld;
      logic [63:0] v;
      logic [6:0]  lz1;
      logic [6:0]  lz2;
      logic [32:0] axy;
      logic        zy;
      logic        za;
   } nm_type;

   typedef struct packed {
      logic        vld;
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] quo;
      logic [31:0] mq;
      logic [6:0]  lz1;
      logic [6:0]  lz2;
      logic        zy;
      logic        za;
   } rd_type;

   typedef struct packed {
      logic    vld;
      rsp_type data;
   } out_type;

   function automatic dv_type div_step(input dv_type a);
      dv_type      o;
      logic [33:0] tx;
      logic [33:0] tz;
      o  = a;
      tx = {a.rem_x, a.num_x[62]};
      tz = {a.rem_z, a.num_z[62]};
      if (tx >= {1'b0, a.den_x}) begin
         o.rem_x = 33'(tx - {1'b0, a.den_x});
         o.quo_x = {a.quo_x[61:0], 1'b1};
      end else begin
         o.rem_x = tx[32:0];
         o.quo_x = {a.quo_x[61:0], 1'b0};
      end
      if (tz >= {1'b0, a.den_z}) begin
         o.rem_z = 33'(tz - {1'b0, a.den_z});
         o.quo_z = {a.quo_z[61:0], 1'b1};
      end else begin
         o.rem_z = tz[32:0];
         o.quo_z = {a.quo_z[61:0], 1'b0};
      end
      o.num_x = {a.num_x[61:0], 1'b0};
      o.num_z = {a.num_z[61:0], 1'b0};
      return o;
   endfunction

   function automatic rd_type rd_step(input rd_type a);
      rd_type      o;
      logic [32:0] t;
      o = a;
      t = {a.rem, a.num[31]};
      if (t >= {1'b0, a.mq}) begin
         o.rem = 32'(t - {1'b0, a.mq});
         o.quo = {a.quo[30:0], 1'b1};
      end else begin
         o.rem = t[31:0];
         o.quo = {a.quo[30:0], 1'b0};
      end
      o.num = {a.num[30:0], 1'b0};
      return o;
   endfunction

   // hi: shifts of 32, 16, 8; else 4, 2, 1. Returns {lz, word}.
   function automatic logic [70:0] norm3(input logic [63:0] v, input logic [6:0] lz,
                                         input logic hi);
      logic [63:0] w;
      logic [6:0]  n;
      w = v;
      n = lz;
      if (hi) begin
         if (w[63:32] == 32'd0) begin w = {w[31:0], 32'd0}; n = n + 7'd32; end
         if (w[63:48] == 16'd0) begin w = {w[47:0], 16'd0}; n = n + 7'd16; end
         if (w[63:56] == 8'd0)  begin w = {w[55:0], 8'd0};  n = n + 7'd8;  end
      end else begin
         if (w[63:60] == 4'd0)  begin w = {w[59:0], 4'd0};  n = n + 7'd4;  end
         if (w[63:62] == 2'd0)  begin w = {w[61:0], 2'd0};  n = n + 7'd2;  end
         if (w[63] == 1'b0)     begin w = {w[62:0], 1'b0};  n = n + 7'd1;  end
      end
      return {n, w};
   endfunction

   function automatic logic [16:0] to_alpha(input logic [16:0] r);
      logic [16:0] c;
      logic [33:0] p;
      c = (r > ROUGH_ONE) ? ROUGH_ONE : r;
      p = 34'(c * c) + 34'd32768;
      return p[32:16];
   endfunction

   logic [16:0] rough_x_ff;
   logic [16:0] rough_y_ff;
   logic        adv;
   logic        wr_en;

   s1_type  s1_ff,  s1_in;
   dv_type  dv_ff   [0:DIV_STEPS];
   dv_type  dv_in   [0:DIV_STEPS];
   nm_type  sum_ff, sum_in;
   nm_type  na_ff,  na_in;
   nm_type  nb_ff,  nb_in;
   nm_type  mp_ff,  mp_in;
   nm_type  pr_ff,  pr_in;
   nm_type  n2a_ff, n2a_in;
   nm_type  n2b_ff, n2b_in;
   rd_type  rd_ff   [0:RD_STEPS];
   rd_type  rd_in   [0:RD_STEPS];
   out_type out_ff, out_in;

   assign adv       = !out_ff.vld || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = out_ff.vld;
   assign rsp_data  = out_ff.data;
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rough_x_ff <= ROUGH_ONE;
         rough_y_ff <= ROUGH_ONE;
      end else if (wr_en) begin
         if (paddr[2] == REG_ROUGH_X) begin
            rough_x_ff <= pwdata[16:0];
         end else begin
            rough_y_ff <= pwdata[16:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_ROUGH_X) begin
         prdata = {15'd0, rough_x_ff};
      end else begin
         prdata = {15'd0, rough_y_ff};
      end
   end

   always_comb begin
      s1_in.vld = req_valid;
      s1_in.ux  = req_data.dir_x[15] ? 16'(-req_data.dir_x) : 16'(req_data.dir_x);
      s1_in.uy  = req_data.dir_y[15] ? 16'(-req_data.dir_y) : 16'(req_data.dir_y);
      s1_in.uz  = req_data.dir_z[15] ? 16'(-req_data.dir_z) : 16'(req_data.dir_z);
      s1_in.ax  = to_alpha(rough_x_ff);
      s1_in.ay  = to_alpha(rough_y_ff);
   end

   always_comb begin
      logic [31:0] sqx;
      logic [31:0] sqy;
      logic [31:0] sqz;
      sqx = 32'(s1_ff.ux * s1_ff.ux);
      sqy = 32'(s1_ff.uy * s1_ff.uy);
      sqz = 32'(s1_ff.uz * s1_ff.uz);
      dv_in[0].vld   = s1_ff.vld;
      dv_in[0].rem_x = 33'd0;
      dv_in[0].num_x = {sqx[30:0], 32'd0};
      dv_in[0].quo_x = 63'd0;
      dv_in[0].den_x = 33'(s1_ff.ax * s1_ff.ax);
      dv_in[0].rem_z = 33'd0;
      dv_in[0].num_z = {sqz[30:0], 32'd0};
      dv_in[0].quo_z = 63'd0;
      dv_in[0].den_z = 33'(s1_ff.ay * s1_ff.ay);
      dv_in[0].sqy   = sqy[30:0];
      dv_in[0].axy   = 33'(s1_ff.ax * s1_ff.ay);
      dv_in[0].zy    = (s1_ff.uy == 16'd0);
      dv_in[0].za    = (s1_ff.ax == 17'd0) || (s1_ff.ay == 17'd0);
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      assign dv_in[g+1] = div_step(dv_ff[g]);
   end

   always_comb begin
      sum_in.vld = dv_ff[DIV_STEPS].vld;
      sum_in.v   = 64'(dv_ff[DIV_STEPS].sqy) + 64'(dv_ff[DIV_STEPS].quo_x)
                 + 64'(dv_ff[DIV_STEPS].quo_z);
      sum_in.lz1 = 7'd0;
      sum_in.lz2 = 7'd0;
      sum_in.axy = dv_ff[DIV_STEPS].axy;
      sum_in.zy  = dv_ff[DIV_STEPS].zy;
      sum_in.za  = dv_ff[DIV_STEPS].za;
   end

   always_comb begin
      na_in = sum_ff;
      {na_in.lz1, na_in.v} = norm3(sum_ff.v, sum_ff.lz1, 1'b1);
      nb_in = na_ff;
      {nb_in.lz1, nb_in.v} = norm3(na_ff.v, na_ff.lz1, 1'b0);
   end

   always_comb begin
      logic [63:0] sq;
      sq       = nb_ff.v[63:32] * nb_ff.v[63:32];
      mp_in    = nb_ff;
      mp_in.v  = {32'd0, sq[63:32]};
      pr_in    = mp_ff;
      pr_in.v  = 64'(mp_ff.axy * mp_ff.v[31:0]);
   end

   always_comb begin
      n2a_in = pr_ff;
      {n2a_in.lz2, n2a_in.v} = norm3(pr_ff.v, 7'd0, 1'b1);
      n2b_in = n2a_ff;
      {n2b_in.lz2, n2b_in.v} = norm3(n2a_ff.v, n2a_ff.lz2, 1'b0);
   end

   always_comb begin
      rd_in[0].vld = n2b_ff.vld;
      rd_in[0].rem = INV_PI_Q64[63:32];
      rd_in[0].num = INV_PI_Q64[31:0];
      rd_in[0].quo = 32'd0;
      rd_in[0].mq  = n2b_ff.v[63:32];
      rd_in[0].lz1 = n2b_ff.lz1;
      rd_in[0].lz2 = n2b_ff.lz2;
      rd_in[0].zy  = n2b_ff.zy;
      rd_in[0].za  = n2b_ff.za;
   end

   for (genvar g = 0; g < RD_STEPS; g++) begin : g_rd
      assign rd_in[g+1] = rd_step(rd_ff[g]);
   end

   always_comb begin
      logic signed [9:0] sh;
      logic        [9:0] nsh;
      logic       [63:0] wide;
      logic       [31:0] r;
      r    = rd_ff[RD_STEPS].quo;
      sh   = SH_BIAS + signed'({3'd0, rd_ff[RD_STEPS].lz2})
                     + signed'({2'd0, rd_ff[RD_STEPS].lz1, 1'b0});
      nsh  = 10'(-sh);
      wide = {32'd0, r} << sh[4:0];
      out_in.vld = rd_ff[RD_STEPS].vld;
      if (rd_ff[RD_STEPS].zy) begin
         out_in.data = '{density: 32'd0, saturated: 1'b0};
      end else if (rd_ff[RD_STEPS].za) begin
         out_in.data = '{density: 32'hFFFFFFFF, saturated: 1'b1};
      end else if (!sh[9]) begin
         if (sh >= 10'sd32 || wide[63:32] != 32'd0) begin
            out_in.data = '{density: 32'hFFFFFFFF, saturated: 1'b1};
         end else begin
            out_in.data = '{density: wide[31:0], saturated: 1'b0};
         end
      end else if (nsh >= 10'd32) begin
         out_in.data = '{density: 32'd0, saturated: 1'b0};
      end else begin
         out_in.data = '{density: r >> nsh[4:0], saturated: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld  <= 1'b0;
         sum_ff.vld <= 1'b0;
         na_ff.vld  <= 1'b0;
         nb_ff.vld  <= 1'b0;
         mp_ff.vld  <= 1'b0;
         pr_ff.vld  <= 1'b0;
         n2a_ff.vld <= 1'b0;
         n2b_ff.vld <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_ff  <= s1_in;
         sum_ff <= sum_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         mp_ff  <= mp_in;
         pr_ff  <= pr_in;
         n2a_ff <= n2a_in;
         n2b_ff <= n2b_in;
         out_ff <= out_in;
      end
   end

   for (genvar g = 0; g <= DIV_STEPS; g++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g].vld <= 1'b0;
         end else if (adv) begin
            dv_ff[g] <= dv_in[g];
         end
      end
   end

   for (genvar g = 0; g <= RD_STEPS; g++) begin : g_rd_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            rd_ff[g].vld <= 1'b0;
         end else if (adv) begin
            rd_ff[g] <= rd_in[g];
         end
      end
   end

`ifndef ASSERT_OFF
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.density == 32'hFFFFFFFF)
      else $error("saturated response without full-scale density");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rd_rem: assert property (@(posedge clock) disable iff (reset)
      rd_ff[RD_STEPS].vld && !rd_ff[RD_STEPS].za && !rd_ff[RD_STEPS].zy
      |-> rd_ff[RD_STEPS].rem < rd_ff[RD_STEPS].mq)
      else $error("reciprocal divider remainder out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rd_ff[RD_STEPS].vld && req_stall |=> rd_ff[RD_STEPS].vld)
      else $error("pipeline stage lost a request during stall");
`endif

endmodule
`default_nettype wire

// File: tb/sv/ggx_normal_density_eval_unit_test.sv
// Testbench for the GGX normal density evaluation unit: directed and random
// directions under several roughness settings, checked against a local predictor.
// Depends on ggx_nde_pkg and ggx_normal_density_eval_unit.
`default_nettype none
module ggx_normal_density_eval_unit_test;
   import ggx_nde_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] DENS_MAX = 64'hFFFF_FFFF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LATENCY = 105;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [16:0] rough_x_mirror;
   logic [16:0] rough_y_mirror;
   rsp_type     density_queue[$];
   int          error_count;
   int          request_count;
   int          response_count;
   int          saturated_count;
   int          cycle_count;
   int          idle_pct;
   int          stall_pct;
   int          hold_left;

   ggx_normal_density_eval_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] alpha_of(input logic [16:0] rough);
      logic [63:0] c;
      c = (rough > ROUGH_ONE) ? 64'(ROUGH_ONE) : 64'(rough);
      return (c * c + 64'd32768) >> 16;
   endfunction

   function automatic logic [63:0] normalize32(input logic [63:0] v, output int e);
      int len;
      len = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) len = i + 1;
      end
      e = len - 32;
      if (len > 32) return v >> (len - 32);
      return v << (32 - len);
   endfunction

   function automatic rsp_type predict_density(input req_type d);
      rsp_type res;
      logic [63:0] ax, ay, ux, uy, uz, s, ms, mp, mq, r, v;
      int es, ep, eq, sh;
      ax = alpha_of(rough_x_mirror);
      ay = alpha_of(rough_y_mirror);
      ux = d.dir_x < 0 ? 64'(-32'(d.dir_x)) : 64'(d.dir_x);
      uy = d.dir_y < 0 ? 64'(-32'(d.dir_y)) : 64'(d.dir_y);
      uz = d.dir_z < 0 ? 64'(-32'(d.dir_z)) : 64'(d.dir_z);
      res.density = '0;
      res.saturated = 1'b0;
      if (uy == 0) return res;
      res.density = 32'hFFFF_FFFF;
      res.saturated = 1'b1;
      if (ax == 0 || ay == 0) return res;
      s = uy * uy + ((ux * ux) << 32) / (ax * ax) + ((uz * uz) << 32) / (ay * ay);
      ms = normalize32(s, es);
      mp = (ms * ms) >> 32;
      ep = 2 * es + 32;
      mq = normalize32((ax * ay) * mp, eq);
      r = INV_PI_Q64 / mq;
      sh = 4 * DIR_FRAC_BITS - 16 - eq - ep;
      if (sh >= 0) begin
         if (sh >= 32 || r > (DENS_MAX >> sh)) return res;
         v = r << sh;
      end else begin
         v = (-sh < 64) ? (r >> (-sh)) : 64'd0;
      end
      if (v > DENS_MAX) return res;
      res.density = v[31:0];
      res.saturated = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h (response %0d)",
               what, got, want, response_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && !req_stall) begin
         density_queue.push_back(predict_density(req_data));
         request_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (density_queue.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.density, 32'd0);
         end else begin
            want = density_queue.pop_front();
            if (rsp_data.density !== want.density)
               report_mismatch("density", rsp_data.density, want.density);
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp_data.saturated),
                               32'(want.saturated));
            if (want.saturated) saturated_count++;
         end
         response_count++;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_direction(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.dir_x = x;
      req_data.dir_y = y;
      req_data.dir_z = z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      end_requests();
      while (density_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_roughness(input logic index, input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 3'(4 * index);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (index == REG_ROUGH_X) rough_x_mirror = value[16:0];
      else rough_y_mirror = value[16:0];
   endtask

   function automatic logic [15:0] random_component();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'sd0;
         default: return 16'($signed(32'($urandom_range(32768))) - 16384);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [15:0] y;
      for (int i = 0; i < count; i++) begin
         y = random_component();
         if ($urandom_range(3) != 0 && y == 0) y = 16'sd16384;
         send_direction(random_component(), y, random_component());
      end
   endtask

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_direction(16'sd0, 16'sd16384, 16'sd0);
      send_direction(16'sd0, -16'sd16384, 16'sd0);
      send_direction(16'sd16384, 16'sd0, 16'sd0);
      send_direction(16'sd0, 16'sd0, 16'sd0);
      send_direction(16'sh8000, 16'sh8000, 16'sh8000);
      send_direction(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_direction(16'sd11585, 16'sd11585, 16'sd0);
      send_direction(16'sd0, 16'sd1, 16'sd0);
      send_direction(16'sd16384, 16'sd1, -16'sd16384);
      send_direction(-16'sd9459, 16'sd9459, 16'sd9459);
      write_roughness(REG_ROUGH_X, 32'd0);
      send_direction(16'sd0, 16'sd16384, 16'sd0);
      send_direction(16'sd8000, 16'sd0, 16'sd8000);
      write_roughness(REG_ROUGH_X, 32'd300);
      write_roughness(REG_ROUGH_Y, 32'd181);
      send_direction(16'sd0, 16'sd16384, 16'sd0);
      send_direction(16'sd16384, 16'sd100, 16'sd0);
      write_roughness(REG_ROUGH_X, 32'hFFFF_FFFF);
      write_roughness(REG_ROUGH_Y, 32'h0001_FFFF);
      send_direction(16'sd0, 16'sd16384, 16'sd0);
      send_direction(16'sd5000, 16'sd12000, -16'sd8000);
      write_roughness(REG_ROUGH_X, 32'd65536);
      write_roughness(REG_ROUGH_Y, 32'd65536);
   endtask

   task automatic test_phase(input logic [31:0] rx, input logic [31:0] ry,
                             input int idle, input int stall, input int count);
      write_roughness(REG_ROUGH_X, rx);
      write_roughness(REG_ROUGH_Y, ry);
      idle_pct = idle;
      stall_pct = stall;
      send_random(count);
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_left = 400;
      send_random(200);
      wait_drained();
      send_random(20);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      rough_x_mirror = ROUGH_ONE;
      rough_y_mirror = ROUGH_ONE;
      error_count = 0;
      request_count = 0;
      response_count = 0;
      saturated_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_phase(32'd65536, 32'd65536, 0, 0, 220);
      test_phase(32'd30000, 32'd50000, 78, 0, 110);
      test_phase(32'd8000, 32'd20000, 0, 78, 110);
      test_phase(32'd1000, 32'd65535, 7, 7, 110);
      test_phase(32'd65536, 32'd256, 78, 78, 60);
      test_backpressure();

      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      $display("%0d requests over six roughness settings incl. zero alpha and clamp,",
               request_count);
      $display("%0d responses checked, %0d saturated, %0d mismatches",
               response_count, saturated_count, error_count);
      if (error_count == 0 && density_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
